@@ design/pdd_pkg.sv @@
package pdd_pkg;

  // widths of the transaction fields
  localparam int CHAR_W    = 8;
  localparam int OUT_W     = 32;
  localparam int CNT_W     = 16;
  localparam int COORD_W   = 32;

  // chunk gathering
  localparam int ACC_W       = 32;
  localparam int IDX_W       = 3;
  localparam int CHUNK_BITS  = 5;
  localparam int MAX_CHUNKS  = 7;
  localparam int SHAMT_W     = 6;
  localparam int SHIFT_W     = ACC_W + CHUNK_BITS;
  localparam logic [CHAR_W-1:0] CHAR_OFFSET = 8'd63;
  localparam logic [CHAR_W-1:0] CONT_FLAG   = 8'h20;
  localparam logic [CHAR_W-1:0] CONT_CODE   = CHAR_OFFSET + CONT_FLAG;

  // register reset
  localparam logic [CNT_W-1:0] MAX_POINTS_RST = 16'hFFFF;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // one classified character handed to the back end
  typedef struct packed {
    logic [COORD_W-1:0] delta;     // zigzag-decoded value, sign extended
    logic               fin;       // a value finished on this character
    logic               is_lon;    // finished value belongs to longitude
    logic               last;      // final character of the string
    logic               err_open;  // string would end mid-value or mid-pair
  } token_t;

  // zigzag decode of a gathered value, sign extended to the sum width
  function automatic logic [COORD_W-1:0] zigzag(input logic [ACC_W-1:0] r);
    logic [ACC_W-1:0] h;
    h = {r[ACC_W-1], r[ACC_W-1:1]};
    if (r[0]) begin
      h = ~h;
    end
    return COORD_W'(signed'(h));
  endfunction

endpackage

@@ design/polyline_delta_decoder.sv @@
// Encoded polyline decoder, one character per transaction. A transaction is
// accepted in every cycle in which in_stall is low; in_stall rises only when
// the four-deep queue between the character front end and the summing back
// end is full, which happens only while out_stall holds results back. The
// front end gathers the 5-bit chunks and zigzag-decodes each finished value
// in the cycle the character arrives; the back end adds it to the running
// latitude or longitude with one shared adder and registers a result for
// the character that completes a pair or carries last_char. Characters that
// neither finish a value nor end the string give no result. Points are
// integers in units of 10^-precision degrees. The user writes max_points
// through cfg_wr_en/cfg_wr_data only while the block is idle, which the
// block does not enforce; decoding stops at the first pair beyond max_points.
module polyline_delta_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pdd_pkg::CNT_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pdd_pkg::CHAR_W-1:0]        in_char_code,
  input  logic                              in_last_char,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_point_valid,
  output logic signed [pdd_pkg::OUT_W-1:0]  out_latitude,
  output logic signed [pdd_pkg::OUT_W-1:0]  out_longitude,
  output logic                              out_done_res,
  output logic                              out_decode_error,
  output logic [pdd_pkg::CNT_W-1:0]         out_point_count
);
  import pdd_pkg::*;

  logic   q_full;
  logic   q_push;
  token_t q_push_data;
  logic   q_valid;
  logic   q_pop;
  token_t q_data;

  // character front end
  pdd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .in_stall     (in_stall),
    .q_push       (q_push),
    .q_data       (q_push_data)
  );

  // decoupling queue
  pdd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // summing back end and result register
  pdd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_point_valid  (out_point_valid),
    .out_latitude     (out_latitude),
    .out_longitude    (out_longitude),
    .out_done_res     (out_done_res),
    .out_decode_error (out_decode_error),
    .out_point_count  (out_point_count)
  );

endmodule

@@ design/pdd_front.sv @@
module pdd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [pdd_pkg::CHAR_W-1:0] in_char_code,
  input  logic                    in_last_char,
  input  logic                    q_full,
  output logic                    in_stall,
  output logic                    q_push,
  output pdd_pkg::token_t         q_data
);
  import pdd_pkg::*;

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               in_value_r, in_value_nxt;
  logic               phase_r, phase_nxt;

  logic               fire;
  logic               cont;
  logic [CHAR_W-1:0]  offs;
  logic [SHIFT_W-1:0] placed;
  logic [ACC_W-1:0]   merged;

  assign in_stall = q_full;
  assign fire     = in_valid && !q_full;

  // classify the character: high bytes act as negative and always end a value
  assign cont   = !in_char_code[CHAR_W-1] && (in_char_code >= CONT_CODE);
  assign offs   = in_char_code - CHAR_OFFSET;
  assign placed = SHIFT_W'(offs[CHUNK_BITS-1:0]) << (SHAMT_W'(idx_r) * SHAMT_W'(CHUNK_BITS));
  assign merged = (idx_r < IDX_W'(MAX_CHUNKS)) ? (acc_r | placed[ACC_W-1:0]) : acc_r;

  // token towards the back end
  always_comb begin
    q_data.delta    = zigzag(merged);
    q_data.fin      = !cont;
    q_data.is_lon   = phase_r;
    q_data.last     = in_last_char;
    q_data.err_open = cont ? 1'b1 : !phase_r;
    q_push          = fire && (!cont || in_last_char);
  end

  // gathering state
  always_comb begin
    acc_nxt      = acc_r;
    idx_nxt      = idx_r;
    in_value_nxt = in_value_r;
    phase_nxt    = phase_r;
    if (fire) begin
      if (in_last_char) begin
        acc_nxt      = '0;
        idx_nxt      = '0;
        in_value_nxt = 1'b0;
        phase_nxt    = 1'b0;
      end else if (!cont) begin
        acc_nxt      = '0;
        idx_nxt      = '0;
        in_value_nxt = 1'b0;
        phase_nxt    = !phase_r;
      end else begin
        acc_nxt      = merged;
        in_value_nxt = 1'b1;
        if (idx_r < IDX_W'(MAX_CHUNKS)) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      idx_r      <= '0;
      in_value_r <= 1'b0;
      phase_r    <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      idx_r      <= idx_nxt;
      in_value_r <= in_value_nxt;
      phase_r    <= phase_nxt;
    end
  end

endmodule

@@ design/pdd_queue.sv @@
module pdd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pdd_pkg::token_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            q_valid,
  output pdd_pkg::token_t q_data
);
  import pdd_pkg::*;

  token_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/pdd_back.sv @@
module pdd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pdd_pkg::CNT_W-1:0]      cfg_wr_data,
  input  logic                           q_valid,
  input  pdd_pkg::token_t                q_data,
  output logic                           q_pop,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic                           out_point_valid,
  output logic signed [pdd_pkg::OUT_W-1:0] out_latitude,
  output logic signed [pdd_pkg::OUT_W-1:0] out_longitude,
  output logic                           out_done_res,
  output logic                           out_decode_error,
  output logic [pdd_pkg::CNT_W-1:0]      out_point_count
);
  import pdd_pkg::*;

  logic [CNT_W-1:0]   max_points_r;
  logic [COORD_W-1:0] lat_sum_r, lat_sum_nxt;
  logic [COORD_W-1:0] lat_pend_r, lat_pend_nxt;
  logic [COORD_W-1:0] lon_sum_r, lon_sum_nxt;
  logic [CNT_W-1:0]   points_r, points_nxt;
  logic               stopped_r, stopped_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               pv_r;
  logic [OUT_W-1:0]   lat_out_r;
  logic [OUT_W-1:0]   lon_out_r;
  logic               done_r;
  logic               err_r;
  logic [CNT_W-1:0]   cnt_out_r;

  logic               pv;
  logic               emit;
  logic               err;
  logic [COORD_W-1:0] coord_sum;

  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  // one shared adder: latitude or longitude, never both for one transaction
  assign coord_sum = (q_data.is_lon ? lon_sum_r : lat_sum_r) + q_data.delta;

  // running sums, point count and stop
  always_comb begin
    lat_sum_nxt  = lat_sum_r;
    lat_pend_nxt = lat_pend_r;
    lon_sum_nxt  = lon_sum_r;
    points_nxt   = points_r;
    stopped_nxt  = stopped_r;
    pv           = 1'b0;
    if (q_pop && !stopped_r && q_data.fin) begin
      if (!q_data.is_lon) begin
        lat_pend_nxt = coord_sum;
      end else if (points_r >= max_points_r) begin
        stopped_nxt = 1'b1;
      end else begin
        lat_sum_nxt = lat_pend_r;
        lon_sum_nxt = coord_sum;
        points_nxt  = points_r + 1'b1;
        pv          = 1'b1;
      end
    end
    emit = pv || q_data.last;
    err  = q_data.last && !stopped_nxt && q_data.err_open;
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_points_r <= MAX_POINTS_RST;
      lat_sum_r    <= '0;
      lat_pend_r   <= '0;
      lon_sum_r    <= '0;
      points_r     <= '0;
      stopped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_points_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
      // a final character returns the string state to reset
      if (q_pop && q_data.last) begin
        lat_sum_r  <= '0;
        lat_pend_r <= '0;
        lon_sum_r  <= '0;
        points_r   <= '0;
        stopped_r  <= 1'b0;
      end else begin
        lat_sum_r  <= lat_sum_nxt;
        lat_pend_r <= lat_pend_nxt;
        lon_sum_r  <= lon_sum_nxt;
        points_r   <= points_nxt;
        stopped_r  <= stopped_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      pv_r      <= pv;
      lat_out_r <= OUT_W'(lat_sum_nxt);
      lon_out_r <= OUT_W'(lon_sum_nxt);
      done_r    <= q_data.last;
      err_r     <= err;
      cnt_out_r <= points_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_valid  = pv_r;
  assign out_latitude     = signed'(lat_out_r);
  assign out_longitude    = signed'(lon_out_r);
  assign out_done_res     = done_r;
  assign out_decode_error = err_r;
  assign out_point_count  = cnt_out_r;

endmodule

@@ design/pdd_checker.sv @@
module pdd_sva (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_point_valid,
  input logic signed [pdd_pkg::OUT_W-1:0] out_latitude,
  input logic signed [pdd_pkg::OUT_W-1:0] out_longitude,
  input logic                             out_done_res,
  input logic                             out_decode_error,
  input logic [pdd_pkg::CNT_W-1:0]        out_point_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_latitude)
      && $stable(out_longitude) && $stable(out_point_count))
    else $error("stalled result changed");

  // every result carries a point or ends the string
  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_point_valid || out_done_res)
    else $error("result with neither point nor done");

  // an error is only reported at the end of a string
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decode_error |-> out_done_res)
    else $error("decode error without done");

  // a delivered point is counted
  a_pt_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_valid |-> out_point_count != '0)
    else $error("point delivered with zero count");

endmodule

bind polyline_delta_decoder pdd_sva u_pdd_sva (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_point_valid  (out_point_valid),
  .out_latitude     (out_latitude),
  .out_longitude    (out_longitude),
  .out_done_res     (out_done_res),
  .out_decode_error (out_decode_error),
  .out_point_count  (out_point_count)
);

@@ bench/pdd_checker.sv @@
module pdd_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [pdd_pkg::CNT_W-1:0]        cfg_wr_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [pdd_pkg::CHAR_W-1:0]       in_char_code,
  input  logic                             in_last_char,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             out_point_valid,
  input  logic signed [pdd_pkg::OUT_W-1:0] out_latitude,
  input  logic signed [pdd_pkg::OUT_W-1:0] out_longitude,
  input  logic                             out_done_res,
  input  logic                             out_decode_error,
  input  logic [pdd_pkg::CNT_W-1:0]        out_point_count,
  output int                               fail_count,
  output int                               pending,
  output int                               results_seen,
  output int                               points_seen,
  output int                               error_ends
);
  timeunit 1ns;
  timeprecision 1ps;
  import pdd_pkg::*;

  // one expected result transaction
  typedef struct {
    logic             pv;
    logic [OUT_W-1:0] lat;
    logic [OUT_W-1:0] lon;
    logic             done;
    logic             err;
    logic [CNT_W-1:0] cnt;
  } point_rec_t;

  point_rec_t expected_points[$];

  // decoder state as the block should hold it
  logic [CNT_W-1:0]   point_limit;
  logic [ACC_W-1:0]   acc_bits;
  logic [IDX_W-1:0]   chunk_pos;
  logic               mid_value;
  logic               lon_next_phase;
  logic [COORD_W-1:0] lat_total;
  logic [COORD_W-1:0] lat_staged;
  logic [COORD_W-1:0] lon_total;
  logic [CNT_W-1:0]   points_given;
  logic               halted;

  task automatic clear_string();
    acc_bits       = '0;
    chunk_pos      = '0;
    mid_value      = 1'b0;
    lon_next_phase = 1'b0;
    lat_total      = '0;
    lat_staged     = '0;
    lon_total      = '0;
    points_given   = '0;
    halted         = 1'b0;
  endtask

  // advance the decoder by one character and queue any result it gives
  task automatic decode_char(input logic [CHAR_W-1:0] code, input logic last);
    int                 signed_code;
    int                 offset_val;
    logic [4:0]         chunk;
    logic [ACC_W-1:0]   half;
    logic [COORD_W-1:0] delta;
    logic [COORD_W-1:0] lon_next;
    logic               pv;
    point_rec_t         rec;
    pv = 1'b0;
    if (!halted) begin
      // byte taken as a signed char, then the offset removed
      signed_code = (code >= 8'd128) ? int'(code) - 256 : int'(code);
      offset_val  = signed_code - 63;
      chunk       = 5'(offset_val);
      if (chunk_pos < IDX_W'(MAX_CHUNKS)) begin
        acc_bits  = acc_bits | (ACC_W'(chunk) << (5 * chunk_pos));
        chunk_pos = chunk_pos + 1'b1;
      end
      mid_value = 1'b1;
      if (offset_val < 32) begin
        // zigzag with an arithmetic shift, inverted for odd values
        half = {acc_bits[ACC_W-1], acc_bits[ACC_W-1:1]};
        if (acc_bits[0]) begin
          half = ~half;
        end
        delta     = COORD_W'(signed'(half));
        acc_bits  = '0;
        chunk_pos = '0;
        mid_value = 1'b0;
        if (!lon_next_phase) begin
          lat_staged     = lat_total + delta;
          lon_next_phase = 1'b1;
        end else begin
          lon_next       = lon_total + delta;
          lon_next_phase = 1'b0;
          if (points_given >= point_limit) begin
            halted = 1'b1;
          end else begin
            lat_total    = lat_staged;
            lon_total    = lon_next;
            points_given = points_given + 1'b1;
            pv           = 1'b1;
          end
        end
      end
    end
    if (pv || last) begin
      rec.pv   = pv;
      rec.lat  = OUT_W'(lat_total);
      rec.lon  = OUT_W'(lon_total);
      rec.done = last;
      rec.err  = last && !halted && (mid_value || lon_next_phase);
      rec.cnt  = points_given;
      expected_points.push_back(rec);
    end
    if (last) begin
      clear_string();
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // compare one result transaction against the oldest expectation
  task automatic check_result();
    point_rec_t want;
    results_seen++;
    if (expected_points.size() == 0) begin
      $display("%0t: unexpected result, actual pv %0b lat %0h lon %0h done %0b err %0b cnt %0d",
               $time, out_point_valid, out_latitude, out_longitude, out_done_res,
               out_decode_error, out_point_count);
      fail_count++;
    end else begin
      want = expected_points.pop_front();
      compare_field("point_valid", want.pv, out_point_valid);
      compare_field("latitude", want.lat, out_latitude);
      compare_field("longitude", want.lon, out_longitude);
      compare_field("done_res", want.done, out_done_res);
      compare_field("decode_error", want.err, out_decode_error);
      compare_field("point_count", want.cnt, out_point_count);
      if (want.pv) begin
        points_seen++;
      end
      if (want.err) begin
        error_ends++;
      end
    end
  endtask

  // expectations are queued before results are taken off on the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      point_limit = MAX_POINTS_RST;
      clear_string();
      expected_points.delete();
      fail_count   = 0;
      results_seen = 0;
      points_seen  = 0;
      error_ends   = 0;
    end else begin
      if (cfg_wr_en) begin
        point_limit = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        decode_char(in_char_code, in_last_char);
      end
      if (out_valid && !out_stall) begin
        check_result();
      end
    end
    pending = expected_points.size();
  end

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD   = 80;
  localparam int IDLE_CYCLES = 10;
  localparam int DRAIN_WAIT  = 20;

  typedef enum int {SEND_STREAM, SEND_BURSTY} send_mode_t;
  typedef enum int {RECV_FREE, RECV_RANDOM, RECV_PATTERN, RECV_HEAVY} recv_mode_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [pdd_pkg::CNT_W-1:0]        cfg_wr_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [pdd_pkg::CHAR_W-1:0]       in_char_code = 8'd63;
  logic                             in_last_char = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             out_point_valid;
  logic signed [pdd_pkg::OUT_W-1:0] out_latitude;
  logic signed [pdd_pkg::OUT_W-1:0] out_longitude;
  logic                             out_done_res;
  logic                             out_decode_error;
  logic [pdd_pkg::CNT_W-1:0]        out_point_count;

  int fail_count;
  int exp_pending;
  int results_seen;
  int points_seen;
  int error_ends;

  // stimulus bookkeeping
  logic [7:0] string_bytes[$];
  send_mode_t send_mode = SEND_BURSTY;
  recv_mode_t recv_mode = RECV_RANDOM;
  int         burst_left = 0;
  int         chars_sent = 0;
  int         strings_sent = 0;
  int         settings_used = 1;
  int         holds_asked = 0;
  int         holds_served = 0;
  int         hold_left = 0;
  logic [7:0] stall_pat = 8'b0010_0110;
  int         pat_age = 0;

  polyline_delta_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_valid  (out_point_valid),
    .out_latitude     (out_latitude),
    .out_longitude    (out_longitude),
    .out_done_res     (out_done_res),
    .out_decode_error (out_decode_error),
    .out_point_count  (out_point_count)
  );

  pdd_checker u_point_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_valid  (out_point_valid),
    .out_latitude     (out_latitude),
    .out_longitude    (out_longitude),
    .out_done_res     (out_done_res),
    .out_decode_error (out_decode_error),
    .out_point_count  (out_point_count),
    .fail_count       (fail_count),
    .pending          (exp_pending),
    .results_seen     (results_seen),
    .points_seen      (points_seen),
    .error_ends       (error_ends)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: long hold on request, otherwise its own stall pattern
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      case (recv_mode)
        RECV_FREE: begin
          out_stall <= 1'b0;
        end
        RECV_RANDOM: begin
          out_stall <= ($urandom_range(0, 2) == 0);
        end
        RECV_PATTERN: begin
          stall_pat = {stall_pat[6:0], stall_pat[7]};
          out_stall <= stall_pat[0];
          pat_age++;
          if (pat_age == 64) begin
            pat_age   = 0;
            stall_pat = 8'($urandom);
          end
        end
        default: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  // zigzag-encode one value into polyline characters
  function automatic void append_value(input logic signed [31:0] v);
    logic [31:0] u;
    u = v <<< 1;
    if (v < 0) begin
      u = ~u;
    end
    while (u >= 32'd32) begin
      string_bytes.push_back(8'(((u & 32'h1F) | 32'h20) + 32'd63));
      u = u >> 5;
    end
    string_bytes.push_back(8'(u + 32'd63));
  endfunction

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 5))
      0:       return 32'($urandom_range(0, 31)) - 32'sd16;
      1:       return 32'($urandom_range(0, 2000)) - 32'sd1000;
      2:       return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
      3:       return 32'($urandom);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return 32'($urandom_range(0, 7)) - 32'sd3;
    endcase
  endfunction

  // mostly well-formed strings, with some noise and broken endings
  task automatic build_string(input int max_pairs);
    int n_pairs;
    int pos;
    int cut;
    string_bytes.delete();
    n_pairs = $urandom_range(1, max_pairs);
    for (int i = 0; i < n_pairs; i++) begin
      append_value(random_value());
      append_value(random_value());
    end
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, string_bytes.size() - 1);
      case ($urandom_range(0, 3))
        0: begin
          string_bytes.insert(pos, 8'($urandom_range(1, 255)));
        end
        1: begin
          cut = $urandom_range(1, 6);
          while (cut > 0 && string_bytes.size() > 1) begin
            void'(string_bytes.pop_back());
            cut--;
          end
        end
        2: begin
          string_bytes[pos] = 8'($urandom_range(128, 255));
        end
        default: begin
          string_bytes.push_back(8'($urandom_range(95, 126)));
        end
      endcase
    end
  endtask

  // offer one character, held until accepted; called at a falling edge
  task automatic send_char(input logic [7:0] code, input logic last);
    int gap;
    if (send_mode == SEND_BURSTY && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_valid     <= 1'b1;
    in_char_code <= code;
    in_last_char <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end
    chars_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < string_bytes.size(); i++) begin
      send_char(string_bytes[i], i == string_bytes.size() - 1);
    end
    strings_sent++;
  endtask

  // drop valid and let the block drain completely
  task automatic settle_idle();
    in_valid <= 1'b0;
    wait (exp_pending == 0);
    @(negedge clk);
    repeat (IDLE_CYCLES) @(negedge clk);
  endtask

  // one phase: idle, new max_points, new send and receive modes, then random strings
  task automatic run_phase(input logic [15:0] limit_val, input int n_chars,
                           input send_mode_t s_mode, input recv_mode_t r_mode,
                           input bit long_hold, input int max_pairs);
    int start_chars;
    settle_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit_val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
    send_mode   = s_mode;
    recv_mode   = r_mode;
    burst_left  = 0;
    if (long_hold) begin
      holds_asked++;
    end
    start_chars = chars_sent;
    while (chars_sent - start_chars < n_chars) begin
      build_string(max_pairs);
      send_string();
    end
  endtask

  initial begin
    // reset
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero pair ending on the same character
    string_bytes = '{8'd63, 8'd63};
    send_string();
    // directed: extreme values
    string_bytes.delete();
    append_value(32'sh7FFF_FFFF);
    append_value(32'sh8000_0000);
    send_string();
    // directed: high bytes end values and keep their low bits
    string_bytes = '{8'hFF, 8'h80};
    send_string();
    // directed: overlong value, string ends between latitude and longitude
    string_bytes = '{8'd126, 8'd126, 8'd126, 8'd126, 8'd126, 8'd126, 8'd126, 8'd63};
    send_string();
    // directed: string ends inside a value
    string_bytes = '{8'd126};
    send_string();

    // random phases
    run_phase(16'd0,     60,  SEND_BURSTY, RECV_RANDOM,  1'b0, 3);
    run_phase(16'd1,     90,  SEND_BURSTY, RECV_PATTERN, 1'b0, 3);
    run_phase(16'd2,     80,  SEND_STREAM, RECV_FREE,    1'b0, 4);
    run_phase(16'hFFFF,  100, SEND_STREAM, RECV_FREE,    1'b1, 6);
    run_phase(16'($urandom_range(3, 8)), 90, SEND_BURSTY, RECV_HEAVY, 1'b0, 6);
    run_phase(16'd1,     60,  SEND_STREAM, RECV_RANDOM,  1'b1, 2);
    run_phase(16'hFFFE,  120, SEND_BURSTY, RECV_PATTERN, 1'b0, 8);

    // drain and give the verdict
    in_valid <= 1'b0;
    wait (exp_pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d characters in %0d strings under %0d max_points settings",
             chars_sent, strings_sent, settings_used);
    $display("checked %0d results: %0d points, %0d strings ending in error",
             results_seen, points_seen, error_ends);
    if (fail_count == 0 && exp_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
